@@ hw/rtl/pcss_pkg.sv @@
// pcss_pkg: shared types, codes and constants of the configuration-space scanner
// used by pcss_step and pci_config_space_scanner_core; no dependencies
`timescale 1ns / 1ps

package pcss_pkg;

	localparam int unsigned BUS_COUNT = 256;
	localparam int unsigned OBUF_DEPTH = 4;

	// result kinds
	localparam logic [1:0] KIND_REQ   = 2'd0;
	localparam logic [1:0] KIND_MATCH = 2'd1;
	localparam logic [1:0] KIND_FIN   = 2'd2;

	// scan phases
	localparam logic [1:0] PH_ID  = 2'd0;
	localparam logic [1:0] PH_HDR = 2'd1;
	localparam logic [1:0] PH_FID = 2'd2;
	localparam logic [1:0] PH_CLS = 2'd3;

	// input codes
	localparam logic FUNC_START = 1'b0;

	// configuration register indexes
	localparam logic [2:0] CFG_MATCH_BY_CLASS = 3'd0;
	localparam logic [2:0] CFG_TARGET_VENDOR  = 3'd1;
	localparam logic [2:0] CFG_TARGET_DEVICE  = 3'd2;
	localparam logic [2:0] CFG_TARGET_CLASS   = 3'd3;
	localparam logic [2:0] CFG_MAX_MATCHES    = 3'd4;

	// config space dword offsets
	localparam logic [7:0] REG_ID    = 8'h00;
	localparam logic [7:0] REG_CLASS = 8'h08;
	localparam logic [7:0] REG_HDR   = 8'h0C;

	localparam logic [15:0] VENDOR_NONE = 16'hFFFF;
	localparam logic [4:0]  DEV_LAST    = 5'd31;
	localparam logic [2:0]  FN_LAST     = 3'd7;
	localparam int unsigned HDR_MF_BIT  = 23;

	typedef struct packed {
		logic        func;
		logic [31:0] read_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] bus_number;
		logic [4:0] device_number;
		logic [2:0] function_number;
		logic [7:0] register_offset;
		logic [7:0] match_count;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic        match_by_class;
		logic [15:0] target_vendor;
		logic [15:0] target_device;
		logic [23:0] target_class;
		logic [7:0]  max_matches;
	} cfg_t;

	typedef struct packed {
		logic [1:0] phase;
		logic       active;
		logic [7:0] bus;
		logic [4:0] dev;
		logic [2:0] fn;
		logic       multi_fn;
		logic [7:0] found;
	} scan_state_t;

endpackage

@@ hw/rtl/pcss_step.sv @@
// pcss_step: next-state and result logic for one beat of the scanner
// depends on pcss_pkg
`timescale 1ns / 1ps

module pcss_step import pcss_pkg::*; (
	input  scan_state_t st,
	input  in_item_t    item,
	input  cfg_t        cfg,
	output scan_state_t st_next,
	output out_item_t   res0,
	output out_item_t   res1,
	output logic [1:0]  res_count
);

	logic      do_report;
	logic      do_next_fn;
	logic      do_next_dev;
	logic      do_finish;
	logic      has_match;
	logic      has_final;
	out_item_t match_res;
	out_item_t final_res;
	logic      bus_done;

	assign bus_done = ({1'b0, st.bus} + 9'd1) >= 9'(BUS_COUNT);

	function automatic out_item_t mk_res(input logic [1:0] kind, input logic [7:0] bus,
			input logic [4:0] dev, input logic [2:0] fn, input logic [7:0] offs,
			input logic [7:0] cnt, input logic last);
		out_item_t r;
		r.kind            = kind;
		r.bus_number      = bus;
		r.device_number   = dev;
		r.function_number = fn;
		r.register_offset = offs;
		r.match_count     = cnt;
		r.last            = last;
		return r;
	endfunction

	always_comb begin
		st_next     = st;
		do_report   = 1'b0;
		do_next_fn  = 1'b0;
		do_next_dev = 1'b0;
		do_finish   = 1'b0;
		has_match   = 1'b0;
		has_final   = 1'b0;
		match_res   = '0;
		final_res   = '0;

		if (item.func == FUNC_START) begin
			st_next.bus      = '0;
			st_next.dev      = '0;
			st_next.fn       = '0;
			st_next.multi_fn = 1'b0;
			st_next.found    = '0;
			st_next.phase    = PH_ID;
			st_next.active   = 1'b1;
			if (cfg.max_matches == 8'd0) begin
				do_finish = 1'b1;
			end else begin
				has_final = 1'b1;
				final_res = mk_res(KIND_REQ, st_next.bus, st_next.dev, 3'd0, REG_ID,
					st_next.found, 1'b1);
			end
		end else if (st.active) begin
			unique case (st.phase)
				PH_ID: begin
					if (item.read_data[15:0] == VENDOR_NONE) begin
						do_next_dev = 1'b1;
					end else begin
						st_next.phase = PH_HDR;
						has_final = 1'b1;
						final_res = mk_res(KIND_REQ, st.bus, st.dev, 3'd0, REG_HDR,
							st.found, 1'b1);
					end
				end
				PH_HDR: begin
					st_next.multi_fn = item.read_data[HDR_MF_BIT];
					st_next.fn       = '0;
					st_next.phase    = PH_FID;
					has_final = 1'b1;
					final_res = mk_res(KIND_REQ, st.bus, st.dev, 3'd0, REG_ID,
						st.found, 1'b1);
				end
				PH_FID: begin
					if (cfg.match_by_class) begin
						if (item.read_data[15:0] == VENDOR_NONE) begin
							do_next_fn = 1'b1;
						end else begin
							st_next.phase = PH_CLS;
							has_final = 1'b1;
							final_res = mk_res(KIND_REQ, st.bus, st.dev, st.fn, REG_CLASS,
								st.found, 1'b1);
						end
					end else if (item.read_data[15:0] == cfg.target_vendor &&
							item.read_data[31:16] == cfg.target_device) begin
						do_report = 1'b1;
					end else begin
						do_next_fn = 1'b1;
					end
				end
				PH_CLS: begin
					if (item.read_data[31:8] == cfg.target_class) begin
						do_report = 1'b1;
					end else begin
						do_next_fn = 1'b1;
					end
				end
				default: begin
					do_next_fn = 1'b0;
				end
			endcase
		end

		if (do_report) begin
			st_next.found = st.found + 8'd1;
			has_match = 1'b1;
			match_res = mk_res(KIND_MATCH, st.bus, st.dev, st.fn, 8'd0, st_next.found, 1'b0);
			if (st_next.found >= cfg.max_matches) begin
				do_finish = 1'b1;
			end else begin
				do_next_fn = 1'b1;
			end
		end

		if (do_next_fn) begin
			if (st_next.multi_fn && st_next.fn != FN_LAST) begin
				st_next.fn    = st_next.fn + 3'd1;
				st_next.phase = PH_FID;
				has_final = 1'b1;
				final_res = mk_res(KIND_REQ, st_next.bus, st_next.dev, st_next.fn, REG_ID,
					st_next.found, 1'b1);
			end else begin
				do_next_dev = 1'b1;
			end
		end

		if (do_next_dev) begin
			if (st_next.dev == DEV_LAST && bus_done) begin
				do_finish = 1'b1;
			end else begin
				if (st_next.dev == DEV_LAST) begin
					st_next.bus = st_next.bus + 8'd1;
					st_next.dev = '0;
				end else begin
					st_next.dev = st_next.dev + 5'd1;
				end
				st_next.fn    = '0;
				st_next.phase = PH_ID;
				has_final = 1'b1;
				final_res = mk_res(KIND_REQ, st_next.bus, st_next.dev, 3'd0, REG_ID,
					st_next.found, 1'b1);
			end
		end

		if (do_finish) begin
			st_next.active = 1'b0;
			st_next.phase  = PH_ID;
			has_final = 1'b1;
			final_res = mk_res(KIND_FIN, 8'd0, 5'd0, 3'd0, 8'd0, st_next.found, 1'b1);
		end
	end

	assign res0      = has_match ? match_res : final_res;
	assign res1      = final_res;
	assign res_count = {1'b0, has_match} + {1'b0, has_final};

endmodule

@@ hw/rtl/pci_config_space_scanner_core.sv @@
// pci_config_space_scanner_core: top level of the brute-force config-space scanner
// path: an accepted input beat is registered in stage 1; its results then go into the result buffer
// throughput: one input beat per cycle while each yields one result and out_ready stays high;
// a match adds one output beat; the output port moves one beat per cycle via a four-entry buffer
// reset: scan idle, position and count cleared, registers to defaults (max_matches 1)
// depends on pcss_pkg and pcss_step
`timescale 1ns / 1ps

module pci_config_space_scanner_core import pcss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int unsigned PW = $clog2(OBUF_DEPTH);
	localparam int unsigned CW = $clog2(OBUF_DEPTH + 1);

	cfg_t        cfg_q;
	scan_state_t st_q;
	scan_state_t st_next;
	in_item_t    item_s1;
	logic        vld_s1;
	out_item_t   res0;
	out_item_t   res1;
	logic [1:0]  res_count;
	logic        adv;
	logic        pop;

	out_item_t   obuf_q [OBUF_DEPTH];
	logic [PW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] wr_ptr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_by_class <= 1'b0;
			cfg_q.target_vendor  <= '0;
			cfg_q.target_device  <= '0;
			cfg_q.target_class   <= '0;
			cfg_q.max_matches    <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MATCH_BY_CLASS: cfg_q.match_by_class <= cfg_data[0];
				CFG_TARGET_VENDOR:  cfg_q.target_vendor  <= cfg_data[15:0];
				CFG_TARGET_DEVICE:  cfg_q.target_device  <= cfg_data[15:0];
				CFG_TARGET_CLASS:   cfg_q.target_class   <= cfg_data;
				CFG_MAX_MATCHES:    cfg_q.max_matches    <= cfg_data[7:0];
				default:            cfg_q.max_matches    <= cfg_q.max_matches;
			endcase
		end
	end

	// stage 1 holds the accepted beat until the buffer has room for two results
	assign adv      = vld_s1 && (count_q <= CW'(OBUF_DEPTH - 2));
	assign in_ready = !vld_s1 || adv;
	assign pop      = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	pcss_step u_step (
		.st        (st_q),
		.item      (item_s1),
		.cfg       (cfg_q),
		.st_next   (st_next),
		.res0      (res0),
		.res1      (res1),
		.res_count (res_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_next;
		end
	end

	// result buffer
	assign wr_ptr = head_q + PW'(count_q);

	always_ff @(posedge clk) begin
		if (adv && res_count != 2'd0) begin
			obuf_q[wr_ptr] <= res0;
			if (res_count == 2'd2) begin
				obuf_q[wr_ptr + PW'(1)] <= res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + PW'(1);
			end
			count_q <= count_q + (adv ? CW'(res_count) : CW'(0)) - (pop ? CW'(1) : CW'(0));
		end
	end

	assign out_valid = count_q != '0;
	assign out_data  = obuf_q[head_q];

`ifndef SYNTH
	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(OBUF_DEPTH))
		else $error("result buffer overfilled");

	a_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.active |-> st_q.phase == PH_ID)
		else $error("idle scanner left in a busy phase");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_count == 2'd2 |-> res0.kind == KIND_MATCH && !res0.last && res1.last)
		else $error("two-result beat not a match followed by its closing result");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv |=> vld_s1 && $stable(item_s1))
		else $error("stalled stage 1 beat lost");
`endif

endmodule
